// File: rtl/core/arpc_pkg.sv
// Shared package for the ARP cache with next-hop selection.
// Holds defaults, register and operation codes, and the search token types.
// No dependencies; every other file depends on this package.
`timescale 1ns / 1ps

package arpc_pkg;

  // Default table depth and fixed field widths
  localparam int CACHE_ENTRIES_DEF = 8;
  localparam int IP_W              = 32;
  localparam int MAC_W             = 48;
  localparam int SLOT_W            = 3;
  localparam int CFG_IDX_W         = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP  = 2'd2;

  // Operation codes
  localparam logic OP_LEARN   = 1'b0;
  localparam logic OP_RESOLVE = 1'b1;

  // Search token passed down the row of cells
  typedef struct packed {
    logic             vld;
    logic             op;
    logic [IP_W-1:0]  ip;    // key: learned address or chosen next hop
    logic [MAC_W-1:0] mac;   // learn data, or found MAC on resolve
    logic             hit;   // a valid entry matched the key
    logic             free;  // a free entry was seen
  } tok_t;

  // Entry write broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } wr_t;

endpackage

// File: rtl/core/arpc_if.sv
// Channel interfaces for the ARP cache: request, result and config write.
// Depends on arpc_pkg for field widths.
`timescale 1ns / 1ps

interface arpc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [arpc_pkg::IP_W-1:0]  ip_addr;
  logic [arpc_pkg::MAC_W-1:0] mac_addr;
  modport source (output valid, op, ip_addr, mac_addr, input ready);
  modport sink   (input valid, op, ip_addr, mac_addr, output ready);
endinterface

interface arpc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic [arpc_pkg::MAC_W-1:0]  found_mac;
  logic [arpc_pkg::IP_W-1:0]   next_hop_ip;
  logic [arpc_pkg::SLOT_W-1:0] slot_index;
  modport source (output valid, hit, found_mac, next_hop_ip, slot_index, input ready);
  modport sink   (input valid, hit, found_mac, next_hop_ip, slot_index, output ready);
endinterface

interface arpc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [arpc_pkg::CFG_IDX_W-1:0] index;
  logic [arpc_pkg::IP_W-1:0]      wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

// File: rtl/core/arpc_cell.sv
// One cache entry of the cell row: holds valid, address and MAC, and
// updates the passing search token. Depends on arpc_pkg.
`timescale 1ns / 1ps

module arpc_cell #(
  parameter int IDX_W = 3,
  parameter int IDX   = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  arpc_pkg::tok_t      tok_i,
  input  logic [IDX_W-1:0]    hit_idx_i,
  input  logic [IDX_W-1:0]    free_idx_i,
  input  arpc_pkg::wr_t       wr_i,
  input  logic [IDX_W-1:0]    wr_idx_i,
  output arpc_pkg::tok_t      tok_o,
  output logic [IDX_W-1:0]    hit_idx_o,
  output logic [IDX_W-1:0]    free_idx_o
);
  import arpc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic             valid_r;
  logic [IP_W-1:0]  ip_r;
  logic [MAC_W-1:0] mac_r;
  tok_t             tok_r, tok_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic             wr_here;

  assign wr_here = wr_i.en && (wr_idx_i == MY_IDX);

  // Token update: first match wins, first free entry is remembered
  always_comb begin
    tok_nxt      = tok_i;
    hit_idx_nxt  = hit_idx_i;
    free_idx_nxt = free_idx_i;
    if (tok_i.vld && !tok_i.hit) begin
      if (valid_r && (ip_r == tok_i.ip)) begin
        tok_nxt.hit = 1'b1;
        hit_idx_nxt = MY_IDX;
        if (tok_i.op == OP_RESOLVE) begin
          tok_nxt.mac = mac_r;
        end
      end else if (!valid_r && !tok_i.free) begin
        tok_nxt.free = 1'b1;
        free_idx_nxt = MY_IDX;
      end
    end
  end

  // Control: valid mark and token valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (wr_here) begin
        valid_r <= 1'b1;
      end
    end
  end

  // Entry payload, no reset
  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    if (wr_here) begin
      ip_r  <= wr_i.ip;
      mac_r <= wr_i.mac;
    end
  end

  assign tok_o      = tok_r;
  assign hit_idx_o  = hit_idx_r;
  assign free_idx_o = free_idx_r;

endmodule

// File: rtl/core/arp_cache_with_next_hop_unit.sv
// Top level of the ARP cache with next-hop selection: config registers,
// control sequencer and the row of entry cells.
// Depends on arpc_pkg, arpc_if and arpc_cell.
//
//  Channel | Dir | Handshake     | Payload
//  --------+-----+---------------+-------------------------------------------
//  in_ch   | in  | valid / ready | op, ip_addr, mac_addr
//  out_ch  | out | valid / ready | hit, found_mac, next_hop_ip, slot_index
//  cfg_ch  | in  | valid / ready | index, wdata (cfg_ch.ready is always high)
//
// The input transfer loads the head token, the token walks the cell row one
// entry per cycle, then the result is captured, and then the entry is written
// and the output loaded. The input is ready again in the next cycle.
// One item is in flight at a time; the output register holds the last
// result while the next item is accepted. A stalled output holds the
// sequencer in its done state. Synchronous reset clears all valid marks.
`timescale 1ns / 1ps

module arp_cache_with_next_hop_unit #(
  parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  arpc_in_if.sink    in_ch,
  arpc_out_if.source out_ch,
  arpc_cfg_if.sink   cfg_ch
);
  import arpc_pkg::*;

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t           state_r;
  logic [IP_W-1:0]  local_ip_r, subnet_mask_r, gateway_ip_r;
  tok_t             head_r;
  tok_t             res_tok_r;
  logic [IDX_W-1:0] res_hidx_r, res_fidx_r;

  logic             out_valid_r, out_hit_r;
  logic [MAC_W-1:0] out_mac_r;
  logic [IP_W-1:0]  out_ip_r;
  logic [SLOT_W-1:0] out_slot_r;

  tok_t             tok_w   [CACHE_ENTRIES+1];
  logic [IDX_W-1:0] hidx_w  [CACHE_ENTRIES+1];
  logic [IDX_W-1:0] fidx_w  [CACHE_ENTRIES+1];

  logic             in_xfer, use_gw, out_load;
  logic [IP_W-1:0]  hop;
  logic [IDX_W-1:0] target, res_slot;
  logic [IDX_W+SLOT_W-1:0] slot_ext;
  wr_t              wr;

  // Config writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r    <= '0;
      subnet_mask_r <= '0;
      gateway_ip_r  <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_LOCAL_IP:    local_ip_r    <= cfg_ch.wdata;
        REG_SUBNET_MASK: subnet_mask_r <= cfg_ch.wdata;
        REG_GATEWAY_IP:  gateway_ip_r  <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // Next-hop choice at accept
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign use_gw = (|subnet_mask_r) && (|local_ip_r) && (|gateway_ip_r) &&
                  ((in_ch.ip_addr & subnet_mask_r) != (local_ip_r & subnet_mask_r));
  assign hop = (in_ch.op == OP_RESOLVE && use_gw) ? gateway_ip_r : in_ch.ip_addr;

  // Cell row
  assign tok_w[0]  = head_r;
  assign hidx_w[0] = '0;
  assign fidx_w[0] = '0;

  for (genvar k = 0; k < CACHE_ENTRIES; k++) begin : g_cell
    arpc_cell #(
      .IDX_W (IDX_W),
      .IDX   (k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_i      (tok_w[k]),
      .hit_idx_i  (hidx_w[k]),
      .free_idx_i (fidx_w[k]),
      .wr_i       (wr),
      .wr_idx_i   (target),
      .tok_o      (tok_w[k+1]),
      .hit_idx_o  (hidx_w[k+1]),
      .free_idx_o (fidx_w[k+1])
    );
  end

  // Learn target and reported slot
  assign target   = res_tok_r.hit  ? res_hidx_r :
                    res_tok_r.free ? res_fidx_r : '0;
  assign res_slot = (res_tok_r.op == OP_LEARN) ? target :
                    (res_tok_r.hit ? res_hidx_r : '0);
  assign slot_ext = {{SLOT_W{1'b0}}, res_slot};

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign wr.en    = out_load && (res_tok_r.op == OP_LEARN);
  assign wr.ip    = res_tok_r.ip;
  assign wr.mac   = res_tok_r.mac;

  // Sequencer, head token and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r.vld <= in_xfer;
      // output valid: set on load, cleared by a result transfer
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            head_r.op   <= in_ch.op;
            head_r.ip   <= hop;
            head_r.mac  <= (in_ch.op == OP_LEARN) ? in_ch.mac_addr : '0;
            head_r.hit  <= 1'b0;
            head_r.free <= 1'b0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tok_w[CACHE_ENTRIES].vld) begin
            res_tok_r  <= tok_w[CACHE_ENTRIES];
            res_hidx_r <= hidx_w[CACHE_ENTRIES];
            res_fidx_r <= fidx_w[CACHE_ENTRIES];
            state_r    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_hit_r   <= res_tok_r.hit;
            out_mac_r   <= (res_tok_r.op == OP_LEARN) ? '0 : res_tok_r.mac;
            out_ip_r    <= res_tok_r.ip;
            out_slot_r  <= slot_ext[SLOT_W-1:0];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.found_mac   = out_mac_r;
  assign out_ch.next_hop_ip = out_ip_r;
  assign out_ch.slot_index  = out_slot_r;

endmodule

// File: rtl/core/arpc_checker.sv
// Port-level checks for the ARP cache top level, attached by bind.
// Depends on arpc_pkg and arp_cache_with_next_hop_unit.
`timescale 1ns / 1ps

module arpc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_hit,
  input logic [arpc_pkg::MAC_W-1:0]  out_found_mac,
  input logic [arpc_pkg::IP_W-1:0]   out_next_hop_ip,
  input logic [arpc_pkg::SLOT_W-1:0] out_slot_index
);
  import arpc_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) &&
      $stable(out_found_mac) && $stable(out_next_hop_ip) && $stable(out_slot_index))
    else $error("result changed while stalled");

  // One item at a time: no transfer right after a transfer
  a_in_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !(in_valid && in_ready))
    else $error("back-to-back input transfers");

  // The search runs through the cell row: no result appears right after a transfer
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result too soon after input transfer");

  // Misses and learns without refresh carry no MAC
  a_miss_mac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_found_mac == '0)
    else $error("nonzero MAC on miss");

endmodule

bind arp_cache_with_next_hop_unit arpc_checker u_arpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_hit         (out_ch.hit),
  .out_found_mac   (out_ch.found_mac),
  .out_next_hop_ip (out_ch.next_hop_ip),
  .out_slot_index  (out_ch.slot_index)
);

// File: test/arpc_reply_checker.sv
// Result checker for the ARP cache: tracks the table and the next-hop
// registers, predicts each reply and compares it with what the block returns.
// Depends on arpc_pkg and the channel interfaces in arpc_if.
`timescale 1ns / 1ps

module arpc_reply_checker #(
  parameter int CACHE_ENTRIES = arpc_pkg::CACHE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  arpc_in_if   in_mon,
  arpc_out_if  out_mon,
  arpc_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending,
  output int   hit_count
);
  import arpc_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [MAC_W-1:0]  mac;
    logic [IP_W-1:0]   hop;
    logic [SLOT_W-1:0] slot;
  } reply_t;

  // Shadow copy of the registers and the table
  logic [IP_W-1:0]  own_ip;
  logic [IP_W-1:0]  net_mask;
  logic [IP_W-1:0]  gw_ip;
  logic             tbl_valid [CACHE_ENTRIES];
  logic [IP_W-1:0]  tbl_ip    [CACHE_ENTRIES];
  logic [MAC_W-1:0] tbl_mac   [CACHE_ENTRIES];

  reply_t due_replies[$];

  // Gateway only when routing is fully set up and the target is off-subnet
  function automatic logic [IP_W-1:0] route_next_hop(logic [IP_W-1:0] dst);
    if (net_mask != '0 && own_ip != '0 && gw_ip != '0 &&
        (dst & net_mask) != (own_ip & net_mask))
      return gw_ip;
    return dst;
  endfunction

  // Applies one request to the shadow table and returns the reply it causes
  function automatic reply_t predict_reply(logic op, logic [IP_W-1:0] addr,
                                           logic [MAC_W-1:0] mac);
    reply_t r;
    int     slot;
    int     free_slot;
    r         = '0;
    slot      = -1;
    free_slot = -1;
    if (op == OP_LEARN) begin
      // first matching entry wins; otherwise lowest free one, else entry 0
      for (int k = 0; k < CACHE_ENTRIES; k++) begin
        if (slot < 0) begin
          if (tbl_valid[k] && tbl_ip[k] == addr) slot = k;
          else if (!tbl_valid[k] && free_slot < 0) free_slot = k;
        end
      end
      r.hit = (slot >= 0);
      if (slot < 0) slot = (free_slot >= 0) ? free_slot : 0;
      tbl_valid[slot] = 1'b1;
      tbl_ip[slot]    = addr;
      tbl_mac[slot]   = mac;
      r.hop           = addr;
      r.slot          = slot[SLOT_W-1:0];
    end else begin
      r.hop = route_next_hop(addr);
      for (int k = 0; k < CACHE_ENTRIES; k++) begin
        if (!r.hit && tbl_valid[k] && tbl_ip[k] == r.hop) begin
          r.hit  = 1'b1;
          r.mac  = tbl_mac[k];
          r.slot = k[SLOT_W-1:0];
        end
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Everything is sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    reply_t want;
    reply_t fresh;
    if (!rst_n) begin
      own_ip   = '0;
      net_mask = '0;
      gw_ip    = '0;
      for (int k = 0; k < CACHE_ENTRIES; k++) tbl_valid[k] = 1'b0;
      due_replies.delete();
      fail_count = 0;
      hit_count  = 0;
    end else begin
      // result transfer: compare with the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (due_replies.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, actual hit %b mac %h hop %h slot %0d", $time,
                   out_mon.hit, out_mon.found_mac, out_mon.next_hop_ip, out_mon.slot_index);
        end else begin
          want = due_replies.pop_front();
          check_field("hit", 64'(want.hit), 64'(out_mon.hit));
          check_field("found_mac", 64'(want.mac), 64'(out_mon.found_mac));
          check_field("next_hop_ip", 64'(want.hop), 64'(out_mon.next_hop_ip));
          check_field("slot_index", 64'(want.slot), 64'(out_mon.slot_index));
        end
      end
      // register write; unused indexes are dropped
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_LOCAL_IP:    own_ip   = cfg_mon.wdata;
          REG_SUBNET_MASK: net_mask = cfg_mon.wdata;
          REG_GATEWAY_IP:  gw_ip    = cfg_mon.wdata;
          default: ;
        endcase
      end
      // request transfer
      if (in_mon.valid && in_mon.ready) begin
        fresh = predict_reply(in_mon.op, in_mon.ip_addr, in_mon.mac_addr);
        if (in_mon.op == OP_RESOLVE && fresh.hit) hit_count++;
        due_replies.push_back(fresh);
      end
    end
    pending = due_replies.size();
  end

  // Leftover expectations are reported once the top stops the run
  final begin
    if (due_replies.size() != 0)
      $display("%0t: %0d results never arrived", $time, due_replies.size());
  end

endmodule

// File: test/arp_cache_with_next_hop_unit_test.sv
// Top of the ARP cache testbench: clock, reset, request and register stimulus,
// result back-pressure and the verdict. Depends on arpc_pkg, arpc_if,
// arpc_reply_checker and the block arp_cache_with_next_hop_unit.
`timescale 1ns / 1ps

module arp_cache_with_next_hop_unit_test;
  import arpc_pkg::*;

  localparam int ENTRIES     = CACHE_ENTRIES_DEF;
  localparam int SETTLE      = ENTRIES + 6;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 180;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  arpc_in_if  in_ch();
  arpc_out_if out_ch();
  arpc_cfg_if cfg_ch();

  int fail_count;
  int pending;
  int hit_count;

  // Stimulus bookkeeping
  logic            tx_steady;
  logic            rx_steady;
  int              hold_reqs = 0;
  logic [IP_W-1:0] cur_local;
  logic [IP_W-1:0] cur_mask;
  logic [IP_W-1:0] cur_gw;
  logic [IP_W-1:0] known_addrs[$];
  int              learns;
  int              resolves;
  int              cfg_writes;
  int              cycle_count = 0;

  arp_cache_with_next_hop_unit #(
    .CACHE_ENTRIES(ENTRIES)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  arpc_reply_checker #(
    .CACHE_ENTRIES(ENTRIES)
  ) u_reply_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .hit_count  (hit_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Result side back-pressure, one decision per falling edge
  initial begin
    int run_left;
    int stall_left;
    int hold_left;
    int hold_seen;
    run_left      = 0;
    stall_left    = 0;
    hold_left     = 0;
    hold_seen     = 0;
    out_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_reqs;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (rx_steady) begin
        out_ch.ready = 1'b1;
      end else if (run_left > 0) begin
        out_ch.ready = 1'b1;
        run_left--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        run_left     = $urandom_range(1, 12);
        stall_left   = pick_gap();
        out_ch.ready = 1'b1;
      end
    end
  end

  // One request transfer; valid stays high for a back-to-back follower
  task automatic send_item(logic op, logic [IP_W-1:0] addr, logic [MAC_W-1:0] mac);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.op       = op;
    in_ch.ip_addr  = addr;
    in_ch.mac_addr = mac;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    if (op == OP_LEARN) begin
      learns++;
      known_addrs.push_back(addr);
    end else begin
      resolves++;
    end
  endtask

  // Wait until every reply is back and the sequencer has settled
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [IP_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.wdata = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    case (idx)
      REG_LOCAL_IP:    cur_local = value;
      REG_SUBNET_MASK: cur_mask  = value;
      REG_GATEWAY_IP:  cur_gw    = value;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic apply_setting(logic [IP_W-1:0] own, logic [IP_W-1:0] mask,
                               logic [IP_W-1:0] gw);
    wait_idle();
    write_reg(REG_LOCAL_IP, own);
    write_reg(REG_SUBNET_MASK, mask);
    write_reg(REG_GATEWAY_IP, gw);
  endtask

  // Random request biased toward addresses the table holds or the router uses
  task automatic send_random_item();
    logic [IP_W-1:0]  addr;
    logic [MAC_W-1:0] mac;
    int               pick;
    int               span;
    int               sz;
    mac[47:32] = 16'($urandom);
    mac[31:0]  = $urandom;
    sz   = known_addrs.size();
    span = (sz > 10) ? 9 : sz - 1;
    pick = $urandom_range(0, 99);
    if (pick < 25) addr = known_addrs[$urandom_range(0, span)];
    else if (pick < 45) addr = known_addrs[sz - 1 - $urandom_range(0, span)];
    else if (pick < 60) addr = (cur_local & cur_mask) | ($urandom & ~cur_mask);
    else if (pick < 70) addr = cur_gw;
    else addr = $urandom;
    send_item(($urandom_range(0, 99) < 40) ? OP_LEARN : OP_RESOLVE, addr, mac);
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_LEARN;
    in_ch.ip_addr  = '0;
    in_ch.mac_addr = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_LOCAL_IP;
    cfg_ch.wdata   = '0;
    tx_steady      = 1'b0;
    rx_steady      = 1'b0;
    cur_local      = '0;
    cur_mask       = '0;
    cur_gw         = '0;
    learns         = 0;
    resolves       = 0;
    cfg_writes     = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Routing off: empty lookup, extreme fields, refresh, fill, overwrite of entry 0
    send_item(OP_RESOLVE, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
    send_item(OP_LEARN, 32'h0000_0000, 48'h0000_0000_0000);
    send_item(OP_LEARN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_item(OP_RESOLVE, 32'hFFFF_FFFF, 48'h0000_0000_0000);
    send_item(OP_RESOLVE, 32'h0000_0000, 48'h0000_0000_0000);
    send_item(OP_LEARN, 32'hFFFF_FFFF, 48'h1234_5678_9ABC);
    for (int k = 0; k < 6; k++)
      send_item(OP_LEARN, 32'h0A00_0010 + k, 48'hA5A5_0000_0000 + k);
    send_item(OP_LEARN, 32'hC0A8_0001, 48'h5A5A_5A5A_5A5A);
    send_item(OP_RESOLVE, 32'h0000_0000, 48'h0);
    send_item(OP_RESOLVE, 32'hC0A8_0001, 48'h0);

    // Gateway routing: off-subnet lookups go to the gateway
    apply_setting(32'h0A00_0001, 32'hFFFF_FF00, 32'h0A00_00FE);
    send_item(OP_RESOLVE, 32'h0808_0808, 48'h0);
    send_item(OP_LEARN, 32'h0A00_00FE, 48'hFEED_FACE_CAFE);
    send_item(OP_RESOLVE, 32'h0808_0808, 48'h0);
    send_item(OP_RESOLVE, 32'h0A00_0012, 48'h0);
    send_item(OP_RESOLVE, 32'h0A00_0001, 48'h0);

    // Random phases, each under its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_setting(32'hC0A8_0101, 32'hFFFF_FFFF, 32'hC0A8_01FE);
        1: apply_setting($urandom, 32'hFFFF_0000, $urandom);
        2: apply_setting($urandom, 32'h0000_0000, $urandom);
        3: apply_setting($urandom, 32'hFFFF_FF00, 32'h0000_0000);
        4: apply_setting(32'h0000_0000, 32'hFF00_0000, $urandom);
        default: apply_setting(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      endcase
      if (ph == 2) write_reg(REG_SPARE, $urandom);
      tx_steady = (ph % 3 == 1);
      rx_steady = (ph % 3 == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long result stall while requests keep coming
        if (n == 60 && (ph == 1 || ph == 4)) hold_reqs++;
        send_random_item();
      end
    end

    wait_idle();
    $display("Covered %0d learns and %0d resolves (%0d resolve hits)",
             learns, resolves, hit_count);
    $display("over %0d register writes, with gateway routing on and off", cfg_writes);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
